@@ hw/rtl/rfo_pkg.sv @@
// shared types and constants for the ring fifo with overwrite
// no dependencies; imported by every module of the block
package rfo_pkg;

	localparam int DEPTH       = 1024;
	localparam int SAMPLE_BITS = 64;
	localparam int READ_MAX    = 64;
	localparam int PTR_W       = $clog2(DEPTH);
	localparam int CNT_W       = 11;
	localparam int FUNC_W      = 3;
	localparam int RM_W        = $clog2(READ_MAX + 1);

	// function codes
	localparam logic [FUNC_W-1:0] F_WR_OVER  = 3'd0;
	localparam logic [FUNC_W-1:0] F_TRY_PART = 3'd1;
	localparam logic [FUNC_W-1:0] F_TRY_ALL  = 3'd2;
	localparam logic [FUNC_W-1:0] F_READ     = 3'd3;
	localparam logic [FUNC_W-1:0] F_CLEAR    = 3'd4;

	typedef struct packed {
		logic [FUNC_W-1:0]      func;
		logic [SAMPLE_BITS-1:0] sample;
		logic [CNT_W-1:0]       burst_len;
		logic                   first_of_burst;
	} req_word_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] out_sample;
		logic                   out_valid;
		logic                   last;
		logic                   accepted;
		logic [CNT_W-1:0]       admitted_count;
		logic [CNT_W-1:0]       used_count;
	} rsp_word_t;

	// controller to datapath
	typedef struct packed {
		logic cfg_wr;
		logic single;
		logic rd_start;
		logic rd_req;
		logic rd_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rd_none;
		logic rd_last;
		logic out_free;
	} sts_t;

endpackage

@@ hw/rtl/ring_fifo_with_overwrite.sv @@
// top level of the ring fifo with overwrite: controller plus datapath
// depends on rfo_pkg, rfo_ctrl, rfo_dpath
//
// usage
//  - req channel (req_valid, req_stall, req_data): one word per item; write kinds
//    carry one sample each, the first word of a burst carries the burst length
//  - rsp channel (rsp_valid, rsp_stall, rsp_data): one word per write, clear or
//    unknown func; a read gives one word per sample returned, last marked, or a
//    single empty word when nothing is available
//  - cfg channel (cfg_valid, cfg_ready, cfg_data): capacity; a write empties the
//    ring and is taken only between items (cfg_ready is high when idle)
//  - ordering: a single-word result is in the output register the cycle after its
//    item; a read is a start, then per sample a memory request and an output load
//  - throughput: writes, clears, empty reads go at one per clock while output is
//    free; a read blocks new items until its last sample is loaded, set by the
//    registered read port of the single ring memory feeding the output register
//  - reset: pointers and fill clear, capacity returns to 1024; the ring memory
//    itself is not cleared, so no clearing pass and no reset wait
//  - receiver stall: the output register holds its word; the block takes one more
//    item only when that register is free or drained in the same cycle
module ring_fifo_with_overwrite (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  rfo_pkg::req_word_t        req_data,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output rfo_pkg::rsp_word_t        rsp_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [rfo_pkg::CNT_W-1:0] cfg_data
);
	import rfo_pkg::*;

	// command and status between the two halves
	cmd_t cmd;
	sts_t sts;

	// controller: handshakes and the read sequence
	rfo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.func      (req_data.func),
		.req_stall (req_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: memory, pointers, counters, result register
	rfo_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule

@@ hw/rtl/rfo_ctrl.sv @@
// controller state machine of the ring fifo: sequences reads, gates handshakes
// depends on rfo_pkg
module rfo_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic [rfo_pkg::FUNC_W-1:0] func,
	output logic                       req_stall,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  rfo_pkg::sts_t              sts,
	output rfo_pkg::cmd_t              cmd
);
	import rfo_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'b001,
		ST_RD_REQ  = 3'b010,
		ST_RD_DATA = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   acc;

	assign cfg_ready = (state_q == ST_IDLE);
	assign req_stall = !((state_q == ST_IDLE) && sts.out_free && !cfg_valid);
	assign acc       = req_valid && !req_stall;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		cmd.cfg_wr = cfg_valid && cfg_ready;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if ((func == F_READ) && !sts.rd_none) begin
						cmd.rd_start = 1'b1;
						state_d      = ST_RD_REQ;
					end else begin
						cmd.single = 1'b1;
					end
				end
			end
			ST_RD_REQ: begin
				cmd.rd_req = 1'b1;
				state_d    = ST_RD_DATA;
			end
			ST_RD_DATA: begin
				if (sts.out_free) begin
					cmd.rd_load = 1'b1;
					state_d     = sts.rd_last ? ST_IDLE : ST_RD_REQ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	property p_read_steps_idle_free;
		@(posedge clk) disable iff (!arst_n)
			(state_q == ST_RD_REQ) |-> !cmd.single && !cmd.rd_start && req_stall;
	endproperty
	a_read_steps_idle_free: assert property (p_read_steps_idle_free)
		else $error("item taken while a read is in progress");

	property p_req_follows_start;
		@(posedge clk) disable iff (!arst_n)
			cmd.rd_start |=> cmd.rd_req;
	endproperty
	a_req_follows_start: assert property (p_req_follows_start)
		else $error("read start not followed by a memory request");

	property p_cfg_only_idle;
		@(posedge clk) disable iff (!arst_n)
			cmd.cfg_wr |-> !cmd.single && !cmd.rd_start && !cmd.rd_req && !cmd.rd_load;
	endproperty
	a_cfg_only_idle: assert property (p_cfg_only_idle)
		else $error("capacity write overlaps other work");

endmodule

@@ hw/rtl/rfo_dpath.sv @@
// datapath of the ring fifo: ring memory, pointers, fill and burst counters,
// result register; depends on rfo_pkg
module rfo_dpath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rfo_pkg::req_word_t       req_data,
	input  logic [rfo_pkg::CNT_W-1:0] cfg_data,
	input  rfo_pkg::cmd_t            cmd,
	output rfo_pkg::sts_t            sts,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output rfo_pkg::rsp_word_t       rsp_data
);
	import rfo_pkg::*;

	logic [SAMPLE_BITS-1:0] mem [DEPTH];
	logic [SAMPLE_BITS-1:0] rdata_q;

	logic [CNT_W-1:0] cap_q, fill_q, grant_q, idx_q;
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [RM_W-1:0]  rem_q;
	logic             rsp_valid_q;
	rsp_word_t        rsp_q, rsp_single;

	logic             is_wr, store, fill_ovf, wr_en;
	logic [CNT_W-1:0] freesp, grant_n, idx_n, fill_inc, fill_w, cap_new;
	logic [CNT_W-1:0] blen_rd, n_rd, wp_inc, rp_inc;
	logic [PTR_W-1:0] wp_e, wp_nx, rp_e, rp_nx;

	// capacity as used: zero acts as one, above depth acts as depth
	always_comb begin
		if (cfg_data == '0)
			cap_new = CNT_W'(1);
		else if (cfg_data > CNT_W'(DEPTH))
			cap_new = CNT_W'(DEPTH);
		else
			cap_new = cfg_data;
	end

	assign is_wr = (req_data.func == F_WR_OVER) || (req_data.func == F_TRY_PART) ||
	               (req_data.func == F_TRY_ALL);

	// grant decided on the first word of a burst
	assign freesp = (fill_q < cap_q) ? (cap_q - fill_q) : '0;
	always_comb begin
		grant_n = grant_q;
		idx_n   = idx_q;
		if (req_data.first_of_burst) begin
			idx_n = '0;
			case (req_data.func)
				F_WR_OVER:  grant_n = req_data.burst_len;
				F_TRY_PART: grant_n = (req_data.burst_len < freesp) ? req_data.burst_len
				                                                   : freesp;
				default:    grant_n = (req_data.burst_len <= freesp) ? req_data.burst_len
				                                                    : '0;
			endcase
		end
	end
	assign store = idx_n < grant_n;
	assign wr_en = cmd.single && is_wr && store;

	// write pointer advance with wrap at capacity
	assign wp_e     = ({1'b0, wp_q} < cap_q) ? wp_q : '0;
	assign wp_inc   = {1'b0, wp_e} + CNT_W'(1);
	assign wp_nx    = (wp_inc >= cap_q) ? '0 : wp_inc[PTR_W-1:0];
	assign fill_inc = fill_q + CNT_W'(1);
	assign fill_ovf = fill_inc > cap_q;
	assign fill_w   = fill_ovf ? cap_q : fill_inc;

	// read pointer advance
	assign rp_e   = ({1'b0, rp_q} < cap_q) ? rp_q : '0;
	assign rp_inc = {1'b0, rp_e} + CNT_W'(1);
	assign rp_nx  = (rp_inc >= cap_q) ? '0 : rp_inc[PTR_W-1:0];

	// read length: request capped at read max and at fill
	assign blen_rd = (req_data.burst_len > CNT_W'(READ_MAX)) ? CNT_W'(READ_MAX)
	                                                         : req_data.burst_len;
	assign n_rd    = (blen_rd < fill_q) ? blen_rd : fill_q;

	assign sts.rd_none  = (n_rd == '0);
	assign sts.rd_last  = (rem_q == RM_W'(1));
	assign sts.out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		rsp_single                = '0;
		rsp_single.last           = 1'b1;
		rsp_single.accepted       = is_wr && store;
		rsp_single.admitted_count = is_wr ? grant_n : '0;
		if (is_wr)
			rsp_single.used_count = store ? fill_w : fill_q;
		else if (req_data.func == F_CLEAR)
			rsp_single.used_count = '0;
		else
			rsp_single.used_count = fill_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wp_e] <= req_data.sample;
		if (cmd.rd_req)
			rdata_q <= mem[rp_e];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CNT_W'(DEPTH);
			fill_q  <= '0;
			grant_q <= '0;
			idx_q   <= '0;
			wp_q    <= '0;
			rp_q    <= '0;
			rem_q   <= '0;
		end else if (cmd.cfg_wr) begin
			cap_q   <= cap_new;
			fill_q  <= '0;
			grant_q <= '0;
			idx_q   <= '0;
			wp_q    <= '0;
			rp_q    <= '0;
		end else if (cmd.single) begin
			if (is_wr) begin
				grant_q <= grant_n;
				idx_q   <= idx_n + CNT_W'(store);
				if (store) begin
					wp_q   <= wp_nx;
					fill_q <= fill_w;
					if (fill_ovf)
						rp_q <= wp_nx;
				end
			end else if (req_data.func == F_CLEAR) begin
				fill_q  <= '0;
				grant_q <= '0;
				idx_q   <= '0;
				wp_q    <= '0;
				rp_q    <= '0;
			end
		end else if (cmd.rd_start) begin
			rem_q <= n_rd[RM_W-1:0];
		end else if (cmd.rd_req) begin
			rp_q   <= rp_nx;
			fill_q <= fill_q - CNT_W'(1);
		end else if (cmd.rd_load) begin
			rem_q <= rem_q - RM_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.single || cmd.rd_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.single) begin
			rsp_q <= rsp_single;
		end else if (cmd.rd_load) begin
			rsp_q.out_sample     <= rdata_q;
			rsp_q.out_valid      <= 1'b1;
			rsp_q.last           <= (rem_q == RM_W'(1));
			rsp_q.accepted       <= 1'b0;
			rsp_q.admitted_count <= '0;
			rsp_q.used_count     <= fill_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	property p_fill_in_cap;
		@(posedge clk) disable iff (!arst_n)
			fill_q <= cap_q;
	endproperty
	a_fill_in_cap: assert property (p_fill_in_cap)
		else $error("fill count above capacity");

	property p_ptrs_in_cap;
		@(posedge clk) disable iff (!arst_n)
			({1'b0, wp_q} < cap_q) && ({1'b0, rp_q} < cap_q);
	endproperty
	a_ptrs_in_cap: assert property (p_ptrs_in_cap)
		else $error("ring pointer outside capacity");

	property p_load_has_count;
		@(posedge clk) disable iff (!arst_n)
			cmd.rd_load |-> (rem_q != '0);
	endproperty
	a_load_has_count: assert property (p_load_has_count)
		else $error("read word loaded with no words left");

	property p_load_slot_free;
		@(posedge clk) disable iff (!arst_n)
			(cmd.single || cmd.rd_load) |-> (!rsp_valid_q || !rsp_stall);
	endproperty
	a_load_slot_free: assert property (p_load_slot_free)
		else $error("result register overwritten while stalled");

	property p_cfg_empties;
		@(posedge clk) disable iff (!arst_n)
			cmd.cfg_wr |=> (fill_q == '0) && (grant_q == '0);
	endproperty
	a_cfg_empties: assert property (p_cfg_empties)
		else $error("capacity write did not empty the ring");

endmodule
